/* src/kdlp_pkg.sv */
// ----------------------------------------------------------------------------
// kdlp_pkg
// types, constants and register codes for the key debounce / long-press block
// ----------------------------------------------------------------------------
package kdlp_pkg;

  localparam int NUM_KEYS = 18;
  localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int KEY_W    = 5;
  localparam int KEY_CW   = 7;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 2;

  localparam logic [CFG_IW-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LONGPRESS = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd10;
  localparam logic [CFG_W-1:0] LONGPRESS_RESET = 16'd750;

  localparam logic [1:0] KS_RELEASED = 2'd0;
  localparam logic [1:0] KS_PRESSED  = 2'd1;
  localparam logic [1:0] KS_LONG     = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic              event_valid;
    logic [1:0]        event_kind;
    logic [1:0]        previous_kind;
    logic [KEY_W-1:0]  event_key;
    logic [TIME_W-1:0] event_time_ms;
    logic [1:0]        key_state;
  } result_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] holdoff;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] longpress_ms;
  } cfg_t;

  typedef struct packed {
    logic   wr;
    entry_t entry;
  } upd_t;

endpackage

/* src/kdlp_ram.sv */
// ----------------------------------------------------------------------------
// kdlp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kdlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/kdlp_update.sv */
// ----------------------------------------------------------------------------
// kdlp_update
// per-key state update: hold-off check, debounce change and long-press test
// ----------------------------------------------------------------------------
module kdlp_update import kdlp_pkg::*; (
  input  sample_t smp,
  input  logic    in_range,
  input  entry_t  cur,
  input  cfg_t    cfg,
  output result_t res,
  output upd_t    upd
);

  logic              live;
  logic              chg;
  logic              lp;
  logic [TIME_W-1:0] age;

  always_comb begin
    live = in_range && (cur.holdoff < smp.now_ms);
    chg  = (!smp.pressed && cur.status != KS_RELEASED) ||
           (smp.pressed && cur.status == KS_RELEASED);
    age  = smp.now_ms - cur.holdoff;
    lp   = smp.pressed && cur.status == KS_PRESSED &&
           age > TIME_W'(cfg.longpress_ms);

    upd.wr    = live;
    upd.entry = cur;

    res.event_valid   = 1'b0;
    res.event_kind    = KS_RELEASED;
    res.previous_kind = KS_RELEASED;
    res.event_key     = smp.key_index;
    res.event_time_ms = smp.now_ms;
    res.key_state     = in_range ? cur.status : KS_RELEASED;

    if (live && chg) begin
      upd.entry.holdoff  = smp.now_ms + TIME_W'(cfg.debounce_ms);
      upd.entry.status   = smp.pressed ? KS_PRESSED : KS_RELEASED;
      res.event_valid    = 1'b1;
      res.previous_kind  = cur.status;
      res.event_kind     = upd.entry.status;
      res.key_state      = upd.entry.status;
    end else if (live && lp) begin
      upd.entry.status   = KS_LONG;
      res.event_valid    = 1'b1;
      res.previous_kind  = cur.status;
      res.event_kind     = KS_LONG;
      res.key_state      = KS_LONG;
    end
  end

endmodule

/* src/key_debounce_longpress_top.sv */
// ----------------------------------------------------------------------------
// key_debounce_longpress_top
// debounce and long-press detector for a bank of keys, state held in a ram
// ----------------------------------------------------------------------------
// usage:
//   smp channel (valid/ready) takes one key sample per item: index, pressed
//   bit and millisecond time. res channel (valid/ready) returns exactly one
//   item per sample with the event flag, new and old state, key, time and
//   the key's state after the sample.
//   the per-key state and hold-off time sit in one ram read at acceptance;
//   the update and write-back follow in the update stage, with the write data
//   forwarded to a following sample of the same key.
//   a result is registered from the update stage. throughput: one item per
//   cycle while results are taken, set by the single ram read/write pair.
//   the result register lets a new sample enter while a result waits; when
//   the receiver stalls, one sample waits in the update stage and then
//   smp_ready drops until a result is taken.
//   reset clears per-key valid flags so every key starts released with a
//   zero hold-off, and restores debounce 10 ms and long-press 750 ms.
//   cfg_we writes cfg_data to register cfg_index: 0 debounce, 1 long-press;
//   other indexes are ignored. write only while the block is idle.
// ----------------------------------------------------------------------------
module key_debounce_longpress_top import kdlp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              smp_valid,
  output logic              smp_ready,
  input  sample_t           smp_data,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t              cfg;
  logic [NUM_KEYS-1:0] vld;

  logic              acc;
  logic              in_range;
  logic [KEY_AW-1:0] raddr;

  logic              s1_valid;
  logic              s1_fresh;
  logic              s1_range;
  sample_t           s1_smp;
  logic              rd_vld;
  logic              fwd_hit;
  entry_t            fwd_data;
  entry_t            held;
  entry_t            ram_q;
  entry_t            eff;
  logic              s1_go;
  logic [KEY_AW-1:0] waddr;
  logic              we;

  result_t           res;
  upd_t              upd;

  assign in_range  = KEY_CW'(smp_data.key_index) < KEY_CW'(NUM_KEYS);
  assign raddr     = KEY_AW'(smp_data.key_index);
  assign waddr     = KEY_AW'(s1_smp.key_index);
  assign s1_go     = s1_valid && (!res_valid || res_ready);
  assign smp_ready = !s1_valid || s1_go;
  assign acc       = smp_valid && smp_ready;
  assign we        = s1_go && upd.wr;

  always_comb begin
    if (!s1_fresh) begin
      eff = held;
    end else if (fwd_hit) begin
      eff = fwd_data;
    end else if (rd_vld) begin
      eff = ram_q;
    end else begin
      eff = '0;
    end
  end

  kdlp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(upd.entry),
    .re   (acc && in_range),
    .raddr(raddr),
    .rdata(ram_q)
  );

  kdlp_update u_update (
    .smp     (s1_smp),
    .in_range(s1_range),
    .cur     (eff),
    .cfg     (cfg),
    .res     (res),
    .upd     (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= DEBOUNCE_RESET;
      cfg.longpress_ms <= LONGPRESS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEBOUNCE) begin
        cfg.debounce_ms <= cfg_data;
      end else if (cfg_index == REG_LONGPRESS) begin
        cfg.longpress_ms <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    held     <= eff;
    fwd_data <= upd.entry;
    if (acc) begin
      s1_smp   <= smp_data;
      s1_range <= in_range;
      rd_vld   <= in_range ? vld[raddr] : 1'b0;
    end
    if (s1_go) begin
      res_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      s1_valid  <= 1'b0;
      s1_fresh  <= 1'b0;
      fwd_hit   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      fwd_hit  <= we && acc && in_range && (waddr == raddr);
      s1_fresh <= acc;
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
